>>> rtl/rms_pkg.sv
// Shared constants and control types for the sample block RMS engine.
package rms_pkg;

  // Default configuration of the engine.
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_MAX_BLOCK   = 65536;

  // Fixed widths of the result word.
  localparam int RMS_W   = 16;
  localparam int COUNT_W = 17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // a sample word is taken this cycle
    logic div_load;   // close the block and load the divider
    logic div_step;   // one quotient bit
    logic root_load;  // move the mean into the root unit
    logic root_step;  // one root bit
    logic out_load;   // capture the result word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic block_end;  // the offered sample closes the block
  } status_t;

endpackage

>>> rtl/rms_in_if.sv
// Sample word channel: valid/ready handshake with a sample and an end-of-block flag.
interface rms_in_if #(
  parameter int SAMPLE_BITS = rms_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          last_sample;

  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink (input valid, input sample_value, input last_sample, output ready);
endinterface

>>> rtl/rms_out_if.sv
// Result word channel: valid/ready handshake with the RMS value and the block length.
interface rms_out_if;
  logic                         valid;
  logic                         ready;
  logic [rms_pkg::RMS_W-1:0]    rms_value;
  logic [rms_pkg::COUNT_W-1:0]  sample_count;

  modport source (output valid, output rms_value, output sample_count, input ready);
  modport sink (input valid, input rms_value, input sample_count, output ready);
endinterface

>>> rtl/rms_datapath.sv
// Datapath: square and accumulate, restoring divider and bit-pair square root.
module rms_datapath #(
  parameter int SAMPLE_BITS = rms_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_BLOCK   = rms_pkg::DEF_MAX_BLOCK,
  parameter int CNT_W       = 17,
  parameter int SUM_W       = 47,
  parameter int ROOT_W      = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rms_pkg::cmd_t                 cmd,
  output rms_pkg::status_t              status,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          last_sample,
  output logic [rms_pkg::RMS_W-1:0]     rms_value,
  output logic [rms_pkg::COUNT_W-1:0]   sample_count
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int CUR_W = ROOT_W + 4;

  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic                     sq_pending;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_inc;
  logic [CNT_W-1:0]         divisor;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-1:0]         sum_add;

  logic [SUM_W-1:0]         quo;
  logic [CNT_W-1:0]         rem;
  logic [CNT_W:0]           dtrial;
  logic                     dge;

  logic [RAD_W-1:0]         rad;
  logic [ROOT_W-1:0]        root;
  logic [REM_W-1:0]         srem;
  logic [CUR_W-1:0]         cur;
  logic [CUR_W-1:0]         strial;
  logic [CUR_W-1:0]         sdiff;
  logic                     sge;

  // The most negative sample gives 2^(SAMPLE_BITS-1), which still fits unsigned.
  assign mag = sample_value[SAMPLE_BITS-1] ? (~sample_value + 1'b1) : sample_value;

  assign cnt_inc          = cnt + 1'b1;
  assign status.block_end = last_sample || (cnt_inc == CNT_W'(MAX_BLOCK));
  assign sum_add          = sum + SUM_W'(sq);

  assign dtrial = {rem, quo[SUM_W-1]};
  assign dge    = dtrial >= {1'b0, divisor};

  assign cur    = {srem, rad[RAD_W-1 -: 2]};
  assign strial = {2'b00, root, 2'b01};
  assign sge    = cur >= strial;
  assign sdiff  = cur - strial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      sum        <= '0;
      sq_pending <= 1'b0;
    end else begin
      sq_pending <= cmd.accept;
      if (cmd.accept) begin
        cnt <= status.block_end ? '0 : cnt_inc;
      end
      if (cmd.div_load) begin
        sum <= '0;
      end else if (sq_pending) begin
        sum <= sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq <= mag * mag;
      if (status.block_end) begin
        divisor <= cnt_inc;
      end
    end

    if (cmd.div_load) begin
      quo <= sum_add;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_W-2:0], dge};
      rem <= dge ? CNT_W'(dtrial - {1'b0, divisor}) : CNT_W'(dtrial);
    end

    if (cmd.root_load) begin
      rad  <= RAD_W'(quo);
      root <= '0;
      srem <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      root <= {root[ROOT_W-2:0], sge};
      srem <= sge ? REM_W'(sdiff) : REM_W'(cur);
    end

    if (cmd.out_load) begin
      rms_value    <= rms_pkg::RMS_W'(root);
      sample_count <= rms_pkg::COUNT_W'(divisor);
    end
  end

endmodule

>>> rtl/rms_ctrl.sv
// Controller: sequences accumulation, division, square root and result hand-off.
module rms_ctrl #(
  parameter int DIV_STEPS  = 47,
  parameter int ROOT_STEPS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rms_pkg::cmd_t    cmd,
  input  rms_pkg::status_t status
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [5:0] {
    ST_ACCUM = 6'b000001,
    ST_ADD   = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_PREP  = 6'b001000,
    ST_ROOT  = 6'b010000,
    ST_HOLD  = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [STEP_W-1:0]   step, step_next;
  logic                out_valid_next;

  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.block_end) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_PREP;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_PREP: begin
        cmd.root_load = 1'b1;
        step_next     = '0;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (step == STEP_W'(ROOT_STEPS - 1)) begin
          state_next = ST_HOLD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_HOLD: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  // The result register is never overwritten while it still holds an untaken word.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result word overwritten before it was taken");

  // A sample that closes the block always starts the division sequence.
  a_end_starts_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.block_end) |=> (state == ST_ADD))
    else $error("block end did not start the division");

  // The divider always runs its full number of steps from zero.
  a_div_from_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |=> (state == ST_DIV && step == '0))
    else $error("division did not start at step zero");

  // The root phase follows directly on the last quotient bit.
  a_div_to_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step == STEP_W'(DIV_STEPS - 1)) |=> (state == ST_PREP))
    else $error("division did not hand over to the root unit");

endmodule

>>> rtl/rms_of_sample_block_top.sv
// Top level of the sample block RMS engine: controller, datapath and channel wiring.
//
// This block takes signed samples, one per word on the sample channel, squares each one
// and adds it into an accumulator wide enough that it cannot overflow for blocks of up to
// MAX_BLOCK samples (it is limited to 64 bits, beyond which the sum wraps). A word with
// last_sample set closes the block, as does the sample that brings the count to MAX_BLOCK.
// When a block closes, the engine divides the sum by the sample count and takes the
// integer square root of the truncated mean, rounding down, and offers one result word
// carrying rms_value and sample_count. Within a block samples are taken at one per clock.
// After the closing sample the engine takes no samples until the result is captured: it
// loads the restoring divider, which produces one quotient bit per cycle, then the square
// root unit, which produces one root bit per cycle. The accumulator width is SUM_W =
// min(64, 2*SAMPLE_BITS - 2 + clog2(MAX_BLOCK + 1)) and the root width is ROOT_W =
// ceil(SUM_W / 2); at the default settings these are 47 and 24. The result sits in an
// output register, so the next block can be accumulated while the previous result waits
// to be taken; only when a further block closes with the earlier result still untaken
// does the engine hold in its final state until the result channel accepts it.
module rms_of_sample_block_top #(
  parameter int SAMPLE_BITS = rms_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_BLOCK   = rms_pkg::DEF_MAX_BLOCK
) (
  input  logic     clk,
  input  logic     rst,
  rms_in_if.sink   samples,
  rms_out_if.source results
);

  // Counter width holds MAX_BLOCK itself; the accumulator holds MAX_BLOCK full-scale squares.
  localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
  localparam int SUM_RAW = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
  localparam int ROOT_W  = (SUM_W + 1) / 2;

  rms_pkg::cmd_t    cmd;
  rms_pkg::status_t status;

  rms_ctrl #(
    .DIV_STEPS  (SUM_W),
    .ROOT_STEPS (ROOT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  rms_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_BLOCK   (MAX_BLOCK),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .ROOT_W      (ROOT_W)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_value (samples.sample_value),
    .last_sample  (samples.last_sample),
    .rms_value    (results.rms_value),
    .sample_count (results.sample_count)
  );

endmodule
